// File: hdl/fstc_pkg.sv
// ----------------------------------------------------------------------------
// fstc_pkg
// Shared types and constants for the frame skip throttle controller.
// ----------------------------------------------------------------------------
package fstc_pkg;

    localparam logic [1:0] CMD_FRAME_TIME = 2'd0;
    localparam logic [1:0] CMD_THERMAL    = 2'd1;
    localparam logic [1:0] CMD_MEMORY     = 2'd2;
    localparam logic [1:0] CMD_GATE       = 2'd3;

    localparam logic [2:0] REG_GOOD_TIME   = 3'd0;
    localparam logic [2:0] REG_RECOVER_RUN = 3'd1;
    localparam logic [2:0] REG_MAX_SKIP    = 3'd2;
    localparam logic [2:0] REG_DEGRADE     = 3'd3;
    localparam logic [2:0] REG_RECOVER     = 3'd4;
    localparam logic [2:0] REG_MAX_BLOCKS  = 3'd5;
    localparam logic [2:0] REG_MIN_BLOCKS  = 3'd6;

    localparam logic [2:0] WL_GREEN    = 3'd0;
    localparam logic [2:0] WL_YELLOW   = 3'd1;
    localparam logic [2:0] WL_ORANGE   = 3'd2;
    localparam logic [2:0] WL_RED      = 3'd3;
    localparam logic [2:0] WL_CRITICAL = 3'd4;

    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_THERMAL = 2'd1;
    localparam logic [1:0] REASON_MEMORY  = 2'd2;

    localparam logic [10:0] PRESSURE_SAT = 11'd1500;

    // request to the modulo unit
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [7:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic       done;
        logic       nonzero;
    } mod_rsp_t;

endpackage

// File: hdl/fstc_mod_unit.sv
// ----------------------------------------------------------------------------
// fstc_mod_unit
// Restoring bit-serial remainder of a counter by the skip interval.
// ----------------------------------------------------------------------------
module fstc_mod_unit #(
    parameter int SKIP_WIDTH        = 6,
    parameter int FRAME_COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fstc_pkg::mod_req_t req,
    output fstc_pkg::mod_rsp_t rsp
);
    localparam int CW = $clog2(FRAME_COUNT_WIDTH + 1);

    logic [FRAME_COUNT_WIDTH-1:0] num_reg;
    logic [SKIP_WIDTH-1:0]        div_reg;
    logic [SKIP_WIDTH:0]          rem_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [SKIP_WIDTH:0]          shifted;
    logic [SKIP_WIDTH:0]          rem_next;

    always_comb
    begin
        shifted  = {rem_reg[SKIP_WIDTH-1:0], num_reg[FRAME_COUNT_WIDTH-1]};
        rem_next = (shifted >= {1'b0, div_reg}) ? shifted - {1'b0, div_reg} : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                num_reg  <= req.dividend[FRAME_COUNT_WIDTH-1:0];
                div_reg  <= req.divisor[SKIP_WIDTH-1:0];
                rem_reg  <= '0;
                cnt_reg  <= CW'(FRAME_COUNT_WIDTH);
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[FRAME_COUNT_WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.nonzero = (rem_reg != '0);
endmodule

// File: hdl/frame_skip_throttle_controller.sv
// ----------------------------------------------------------------------------
// frame_skip_throttle_controller
// Adaptive frame skip interval with thermal and memory throttling.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_stall) carries command beats; one
// output channel (out_valid/out_stall) returns one result beat per input.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Frame-time, thermal and memory beats go from ST_IDLE to ST_EXEC to ST_OUT.
// Frame-gate beats with a skip interval above 1 also wait in ST_MOD for a
// bit-serial remainder of the frame counter by the skip interval.
// One beat is in flight at a time; in_stall is high from accept until the
// result leaves the output register. A stalled result holds its value and
// blocks the next input. Reset clears all state, returns the registers to
// their defaults, skip and ceiling to 1, water level green, cap 256.
// ----------------------------------------------------------------------------
module frame_skip_throttle_controller #(
    parameter int SKIP_WIDTH        = 6,
    parameter int FRAME_COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [23:0] frame_time_us,
    input  logic [2:0]  thermal_level,
    input  logic [11:0] pressure_permille,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [SKIP_WIDTH-1:0] skip_interval,
    output logic [SKIP_WIDTH-1:0] thermal_ceiling,
    output logic [2:0]  water_level,
    output logic [15:0] block_budget,
    output logic        frame_skipped,
    output logic [1:0]  skip_cause,
    output logic        change_applied
);
    localparam int SW = SKIP_WIDTH;
    localparam logic [SW-1:0] LIM = {SW{1'b1}};

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_MOD, ST_OUT} state_t;

    state_t state_reg;
    logic [23:0] good_time_reg;
    logic [9:0]  recover_run_reg;
    logic [5:0]  max_skip_reg;
    logic [15:0] degrade_reg, recover_reg, max_blk_reg, min_blk_reg;
    logic [SW-1:0] skip_reg, ceil_reg;
    logic [9:0]  run_reg;
    logic [31:0] therm_time_reg, press_time_reg;
    logic [2:0]  wl_reg;
    logic [15:0] cap_reg;
    logic [FRAME_COUNT_WIDTH-1:0] fcnt_reg;

    logic [1:0]  cmd_reg;
    logic [23:0] ft_reg;
    logic [2:0]  tl_reg;
    logic [11:0] pp_reg;
    logic [31:0] now_reg;
    logic        skipped_reg, applied_reg;
    logic [1:0]  reason_reg;

    fstc_pkg::mod_req_t mreq;
    fstc_pkg::mod_rsp_t mrsp;

    fstc_mod_unit #(.SKIP_WIDTH(SW), .FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)) u_mod (
        .clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    function automatic logic [SW-1:0] clampw(input logic [7:0] v, input logic [SW-1:0] m);
        logic [SW-1:0] r;
        r = (v > 8'(m)) ? m : v[SW-1:0];
        return r;
    endfunction

    logic [SW-1:0] slim, mfloor, sdbl_c, s_ft, s_th, t_tgt, s_mem, wfloor;
    logic [7:0]    t_raw, smx;
    logic [8:0]    sdbl;
    logic [9:0]    run_inc;
    logic [31:0]   el_t, el_p;
    logic [32:0]   el_p2;
    logic          th_pass, m_blocked;
    logic [10:0]   psat;
    logic [2:0]    wtgt, wnew;
    logic [17:0]   mx4, mx3;
    logic [35:0]   rcp5;
    logic [15:0]   capv;

    always_comb
    begin
        smx  = {2'b00, max_skip_reg};
        if (smx == 8'd0)
            smx = 8'd1;
        slim = clampw(smx, LIM);
        case (wl_reg)
            fstc_pkg::WL_YELLOW:   mfloor = clampw(8'd2, slim);
            fstc_pkg::WL_ORANGE:   mfloor = clampw(8'd3, slim);
            fstc_pkg::WL_RED:      mfloor = clampw(8'd4, slim);
            fstc_pkg::WL_CRITICAL: mfloor = slim;
            default:               mfloor = SW'(1);
        endcase
        // frame time
        run_inc = (run_reg == 10'h3FF) ? run_reg : run_reg + 10'd1;
        sdbl    = 9'({skip_reg, 1'b0});
        sdbl_c  = clampw((sdbl > 9'd255) ? 8'hFF : sdbl[7:0],
                         (ceil_reg > slim) ? slim : ceil_reg);
        if (sdbl_c == '0)
            sdbl_c = SW'(1);
        if (ft_reg < good_time_reg)
            s_ft = (run_inc >= recover_run_reg && skip_reg > SW'(1))
                   ? skip_reg - SW'(1) : skip_reg;
        else
            s_ft = sdbl_c;
        if (s_ft < mfloor)
            s_ft = mfloor;
        // thermal
        case (tl_reg)
            3'd0:    t_raw = 8'd1;
            3'd1:    t_raw = 8'd2;
            3'd2:    t_raw = 8'd4;
            3'd3:    t_raw = 8'd12;
            default: t_raw = 8'd2;
        endcase
        t_tgt   = clampw(t_raw, slim);
        el_t    = now_reg - therm_time_reg;
        th_pass = (el_t >= {16'd0, (t_tgt > ceil_reg) ? degrade_reg : recover_reg});
        if (t_tgt > ceil_reg)
            s_th = (skip_reg < t_tgt) ? t_tgt : skip_reg;
        else
            s_th = (skip_reg > t_tgt) ? t_tgt : skip_reg;
        // memory
        psat = (pp_reg > {1'b0, fstc_pkg::PRESSURE_SAT}) ? fstc_pkg::PRESSURE_SAT : pp_reg[10:0];
        if (psat >= 11'd920)      wtgt = fstc_pkg::WL_CRITICAL;
        else if (psat >= 11'd850) wtgt = fstc_pkg::WL_RED;
        else if (psat >= 11'd750) wtgt = fstc_pkg::WL_ORANGE;
        else if (psat >= 11'd600) wtgt = fstc_pkg::WL_YELLOW;
        else                      wtgt = fstc_pkg::WL_GREEN;
        el_p  = now_reg - press_time_reg;
        el_p2 = {el_p, 1'b0};
        m_blocked = (wtgt > wl_reg) ? (el_p2 < {17'd0, degrade_reg})
                                    : (el_p < {16'd0, recover_reg});
        wnew = wtgt;
        mx4 = {max_blk_reg, 2'b00};
        mx3 = {1'b0, max_blk_reg, 1'b0} + {2'b00, max_blk_reg};
        // divide by 5 through a reciprocal multiply
        rcp5 = {18'd0, (wnew == fstc_pkg::WL_ORANGE) ? mx3 : mx4} * 36'd52429;
        case (wnew)
            fstc_pkg::WL_YELLOW:   capv = rcp5[33:18];
            fstc_pkg::WL_ORANGE:   capv = rcp5[33:18];
            fstc_pkg::WL_RED:      capv = max_blk_reg >> 1;
            fstc_pkg::WL_CRITICAL: capv = 16'(({16'd0, max_blk_reg} * 32'd43691) >> 17);
            default:               capv = max_blk_reg;
        endcase
        if (capv > max_blk_reg) capv = max_blk_reg;
        if (capv < min_blk_reg) capv = min_blk_reg;
        case (wnew)
            fstc_pkg::WL_YELLOW:   wfloor = clampw(8'd2, slim);
            fstc_pkg::WL_ORANGE:   wfloor = clampw(8'd3, slim);
            fstc_pkg::WL_RED:      wfloor = clampw(8'd4, slim);
            fstc_pkg::WL_CRITICAL: wfloor = slim;
            default:               wfloor = SW'(1);
        endcase
        s_mem = (skip_reg < wfloor) ? wfloor : skip_reg;
        s_mem = clampw(8'(s_mem), slim);
        mreq.start    = (state_reg == ST_EXEC) && (cmd_reg == fstc_pkg::CMD_GATE)
                        && (skip_reg > SW'(1));
        mreq.dividend = 64'(fcnt_reg);
        mreq.divisor  = 8'(skip_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            good_time_reg <= 24'd11000;  recover_run_reg <= 10'd30;
            max_skip_reg <= 6'd12;       degrade_reg <= 16'd2000;
            recover_reg <= 16'd5000;     max_blk_reg <= 16'd256;
            min_blk_reg <= 16'd32;
            skip_reg <= SW'(1);  ceil_reg <= SW'(1);  run_reg <= '0;
            therm_time_reg <= '0; press_time_reg <= '0;
            wl_reg <= fstc_pkg::WL_GREEN;
            cap_reg <= 16'd256;  fcnt_reg <= '0;
            cmd_reg <= fstc_pkg::CMD_FRAME_TIME; ft_reg <= '0;
            tl_reg <= '0; pp_reg <= '0; now_reg <= '0;
            skipped_reg <= 1'b0; reason_reg <= fstc_pkg::REASON_NONE; applied_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fstc_pkg::REG_GOOD_TIME:   good_time_reg   <= cfg_data;
                    fstc_pkg::REG_RECOVER_RUN: recover_run_reg <= cfg_data[9:0];
                    fstc_pkg::REG_MAX_SKIP:    max_skip_reg    <= cfg_data[5:0];
                    fstc_pkg::REG_DEGRADE:     degrade_reg     <= cfg_data[15:0];
                    fstc_pkg::REG_RECOVER:     recover_reg     <= cfg_data[15:0];
                    fstc_pkg::REG_MAX_BLOCKS:  max_blk_reg     <= cfg_data[15:0];
                    fstc_pkg::REG_MIN_BLOCKS:  min_blk_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= command;  ft_reg <= frame_time_us;
                        tl_reg <= thermal_level; pp_reg <= pressure_permille;
                        now_reg <= now_ms;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    skipped_reg <= 1'b0;
                    reason_reg  <= fstc_pkg::REASON_NONE;
                    applied_reg <= 1'b0;
                    state_reg   <= ST_OUT;
                    case (cmd_reg)
                        fstc_pkg::CMD_FRAME_TIME:
                        begin
                            skip_reg <= s_ft;
                            if (ft_reg < good_time_reg)
                                run_reg <= (run_inc >= recover_run_reg && skip_reg > SW'(1))
                                           ? 10'd0 : run_inc;
                            else
                                run_reg <= '0;
                        end
                        fstc_pkg::CMD_THERMAL:
                        begin
                            if (th_pass)
                            begin
                                ceil_reg <= t_tgt;
                                skip_reg <= (s_th < mfloor) ? mfloor : s_th;
                                therm_time_reg <= now_reg;
                                run_reg <= '0;
                                applied_reg <= 1'b1;
                            end
                        end
                        fstc_pkg::CMD_MEMORY:
                        begin
                            if (!(wtgt != wl_reg && m_blocked))
                            begin
                                if (wtgt != wl_reg)
                                begin
                                    wl_reg <= wtgt;
                                    press_time_reg <= now_reg;
                                    applied_reg <= 1'b1;
                                end
                                cap_reg  <= capv;
                                skip_reg <= s_mem;
                            end
                        end
                        default:
                        begin
                            fcnt_reg <= fcnt_reg + 1'b1;
                            if (skip_reg > SW'(1))
                                state_reg <= ST_MOD;
                        end
                    endcase
                end
                ST_MOD:
                begin
                    if (mrsp.done)
                    begin
                        if (mrsp.nonzero)
                        begin
                            skipped_reg <= 1'b1;
                            reason_reg  <= (wl_reg >= fstc_pkg::WL_ORANGE)
                                           ? fstc_pkg::REASON_MEMORY : fstc_pkg::REASON_THERMAL;
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = (state_reg == ST_OUT);
    assign skip_interval   = skip_reg;
    assign thermal_ceiling = ceil_reg;
    assign water_level     = wl_reg;
    assign block_budget    = cap_reg;
    assign frame_skipped   = skipped_reg;
    assign skip_cause      = reason_reg;
    assign change_applied  = applied_reg;
endmodule
